[hdl/swm_pkg.sv]
// ----------------------------------------------------------------------------
// swm_pkg
// Shared widths and helpers for the shift-within-mask block.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int WORD_BITS  = 32;
  localparam int COUNT_BITS = 8;
  // The step counter must hold WORD_BITS itself.
  localparam int CNT_BITS   = $clog2(WORD_BITS + 1);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  // Bit reversal is only wiring.
  function automatic word_t reverse_word(input word_t w);
    word_t r;
    for (int i = 0; i < WORD_BITS; i++) begin
      r[i] = w[WORD_BITS-1-i];
    end
    return r;
  endfunction

endpackage

[hdl/shift_within_mask_core.sv]
// ----------------------------------------------------------------------------
// shift_within_mask_core
// Shifts the bits of a word that lie under a mask, as one packed field.
// ----------------------------------------------------------------------------
// The accepting edge loads the operands, and the shift magnitude is clamped
// to the word width. The shared add-and-merge unit then takes one step per
// shift position, and a last step in the run state writes the result. That
// last write waits while an earlier result still sits unread in the output
// register. The block accepts one transaction at a time, and in_stall is high
// while it works. The next transaction can be accepted in the cycle after the
// result is written. A finished result may wait in the output register while
// the next transaction is accepted. Negative counts run on the bit-reversed
// word and mask. The block keeps no state between transactions.
module shift_within_mask_core
  import swm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [WORD_BITS-1:0]  in_data_word,
  input  logic [WORD_BITS-1:0]  in_mask_word,
  input  logic signed [COUNT_BITS-1:0] in_shift_count,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [WORD_BITS-1:0]  out_result_word
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic  state_r, state_nxt;
  cnt_t  cnt_r, cnt_nxt;
  logic  neg_r, neg_nxt;
  word_t w_r, w_nxt;
  word_t m_r, m_nxt;
  logic  out_valid_r, out_valid_nxt;
  word_t out_word_r, out_word_nxt;

  word_t step_w;
  logic  in_take;
  logic  in_neg;
  logic [COUNT_BITS:0] in_mag;
  cnt_t  in_cnt;

  swm_step u_step (
    .w_in  (w_r),
    .m_in  (m_r),
    .w_out (step_w)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign in_neg   = in_shift_count[COUNT_BITS-1];
  assign in_mag   = in_neg ? ((COUNT_BITS+1)'(0) - {1'b1, in_shift_count})
                           : {1'b0, in_shift_count};
  assign in_cnt   = (in_mag > (COUNT_BITS+1)'(WORD_BITS)) ? cnt_t'(WORD_BITS)
                                                         : cnt_t'(in_mag);

  assign out_valid       = out_valid_r;
  assign out_result_word = out_word_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    w_nxt         = w_r;
    m_nxt         = m_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          state_nxt = ST_RUN;
          cnt_nxt   = in_cnt;
          neg_nxt   = in_neg;
          w_nxt     = in_neg ? reverse_word(in_data_word) : in_data_word;
          m_nxt     = in_neg ? reverse_word(in_mask_word) : in_mask_word;
        end
      end
      ST_RUN: begin
        if (cnt_r != '0) begin
          w_nxt   = step_w;
          cnt_nxt = cnt_r - cnt_t'(1);
        end else if (!out_valid_r || !out_stall) begin
          // The output register is free or is being emptied this cycle.
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_word_nxt  = neg_r ? reverse_word(w_r) : w_r;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    w_r        <= w_nxt;
    m_r        <= m_nxt;
    out_word_r <= out_word_nxt;
  end

  a_take_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (state_r == ST_RUN))
    else $error("accepted transaction did not start a run");

  a_cnt_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && cnt_r != '0) |=>
      (state_r == ST_RUN && cnt_r == $past(cnt_r) - cnt_t'(1)))
    else $error("step counter did not count down");

  a_cnt_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (cnt_r <= cnt_t'(WORD_BITS)))
    else $error("step counter above word width");

  a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r && out_stall)) |->
      $past(state_r == ST_RUN && cnt_r == '0))
    else $error("result appeared without a finished run");

endmodule

[hdl/swm_step.sv]
// ----------------------------------------------------------------------------
// swm_step
// One shift step of the masked field, done by an add whose carry runs
// across the unmasked positions.
// ----------------------------------------------------------------------------
module swm_step
  import swm_pkg::*;
(
  input  word_t w_in,
  input  word_t m_in,
  output word_t w_out
);

  word_t nm;
  word_t sum;

  assign nm    = ~m_in;
  // A masked one, doubled, carries through the unmasked ones up to the next
  // mask position.
  assign sum   = nm + {w_in[WORD_BITS-2:0] & m_in[WORD_BITS-2:0], 1'b0};
  assign w_out = (nm & w_in) | (m_in & sum);

endmodule
